FILE: rtl/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_UNTERM = 3'd1,
    ERR_CTRL   = 3'd2,
    ERR_ESCAPE = 3'd3,
    ERR_HEX    = 3'd4,
    ERR_TRUNC  = 3'd5
  } err_t;

  // one result as it leaves the block, last_of_run aside
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       done;
    err_t       err;
  } res_t;

  localparam int unsigned MaxRes = 3;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MaxRes-1:0]      ent;
  } grp_t;

endpackage

FILE: rtl/jsu_decode.sv
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_text,
  input  logic       grp_free,
  output logic       grp_load,
  output grp_t       grp
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrSlash  = 8'h2F;
  localparam logic [7:0] ChrLowB   = 8'h62;
  localparam logic [7:0] ChrLowF   = 8'h66;
  localparam logic [7:0] ChrLowN   = 8'h6E;
  localparam logic [7:0] ChrLowR   = 8'h72;
  localparam logic [7:0] ChrLowT   = 8'h74;
  localparam logic [7:0] ChrLowU   = 8'h75;
  localparam logic [7:0] ChrSpace  = 8'h20;

  logic        in_v_r;
  logic [7:0]  char_r;
  logic        end_r;
  mode_t       mode_r, mode_nxt;
  logic [11:0] accum_r, accum_nxt;
  logic [4:0]  hex;
  logic [15:0] code;
  logic        adv;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic grp_t mk_err(input err_t e);
    grp_t g;
    g = '0;
    g.cnt        = 2'd1;
    g.ent[0].err = e;
    return g;
  endfunction

  function automatic grp_t mk_bytes(input logic [1:0] n, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic e);
    grp_t g;
    g = '0;
    g.cnt         = n;
    g.ent[0].data = b0;
    g.ent[1].data = b1;
    g.ent[2].data = b2;
    g.ent[0].has  = 1'b1;
    g.ent[1].has  = 1'b1;
    g.ent[2].has  = 1'b1;
    if (e) begin
      g.ent[n - 2'd1].err = ERR_UNTERM;
    end
    return g;
  endfunction

  assign hex  = hex_value(char_r);
  assign code = {accum_r, hex[3:0]};

  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    grp       = '0;
    unique case (mode_r)
      MODE_NORMAL: begin
        if (char_r == ChrQuote) begin
          accum_nxt        = '0;
          grp.cnt          = 2'd1;
          grp.ent[0].done  = 1'b1;
        end else if (char_r < ChrSpace) begin
          grp = mk_err(ERR_CTRL);
        end else if (char_r == ChrBslash) begin
          if (end_r) begin
            grp = mk_err(ERR_UNTERM);
          end else begin
            mode_nxt = MODE_ESCAPE;
          end
        end else begin
          grp = mk_bytes(2'd1, char_r, 8'h00, 8'h00, end_r);
          if (end_r) accum_nxt = '0;
        end
      end
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        unique case (char_r)
          ChrQuote, ChrBslash, ChrSlash:
                   grp = mk_bytes(2'd1, char_r, 8'h00, 8'h00, end_r);
          ChrLowB: grp = mk_bytes(2'd1, 8'h08, 8'h00, 8'h00, end_r);
          ChrLowF: grp = mk_bytes(2'd1, 8'h0C, 8'h00, 8'h00, end_r);
          ChrLowN: grp = mk_bytes(2'd1, 8'h0A, 8'h00, 8'h00, end_r);
          ChrLowR: grp = mk_bytes(2'd1, 8'h0D, 8'h00, 8'h00, end_r);
          ChrLowT: grp = mk_bytes(2'd1, 8'h09, 8'h00, 8'h00, end_r);
          ChrLowU: begin
            accum_nxt = '0;
            if (end_r) begin
              grp = mk_err(ERR_TRUNC);
            end else begin
              mode_nxt = MODE_HEX0;
            end
          end
          default: begin
            accum_nxt = '0;
            grp       = mk_err(ERR_ESCAPE);
          end
        endcase
        if (end_r) accum_nxt = '0;
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
        if (end_r || !hex[4]) begin
          mode_nxt  = MODE_NORMAL;
          accum_nxt = '0;
          grp       = mk_err(end_r ? ERR_TRUNC : ERR_HEX);
        end else begin
          accum_nxt = {accum_r[7:0], hex[3:0]};
          unique case (mode_r)
            MODE_HEX0: mode_nxt = MODE_HEX1;
            MODE_HEX1: mode_nxt = MODE_HEX2;
            default:   mode_nxt = MODE_HEX3;
          endcase
        end
      end
      MODE_HEX3: begin
        mode_nxt  = MODE_NORMAL;
        accum_nxt = '0;
        if (!hex[4]) begin
          grp = mk_err(ERR_HEX);
        end else if (code[15:7] == '0) begin
          grp = mk_bytes(2'd1, {1'b0, code[6:0]}, 8'h00, 8'h00, end_r);
        end else if (code[15:11] == '0) begin
          grp = mk_bytes(2'd2, {3'b110, code[10:6]}, {2'b10, code[5:0]}, 8'h00, end_r);
        end else begin
          grp = mk_bytes(2'd3, {4'b1110, code[15:12]}, {2'b10, code[11:6]},
                         {2'b10, code[5:0]}, end_r);
        end
      end
      default: begin
        mode_nxt  = MODE_NORMAL;
        accum_nxt = '0;
      end
    endcase
  end

  // a byte without results moves on even while the result register is busy
  assign adv      = in_v_r && (grp_free || grp.cnt == 2'd0);
  assign grp_load = adv && grp.cnt != 2'd0;
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mode_r  <= MODE_NORMAL;
      accum_r <= '0;
    end else begin
      if (adv) begin
        mode_r  <= mode_nxt;
        accum_r <= accum_nxt;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
    end
    if (in_ready && in_valid) begin
      char_r <= in_char_byte;
      end_r  <= in_end_of_text;
    end
  end

  a_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_NORMAL || mode_r == MODE_ESCAPE || mode_r == MODE_HEX0)
      |-> accum_r == '0)
    else $error("digit accumulator not clear outside hex digits");

  a_accum_one: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HEX1 |-> accum_r[11:4] == '0)
    else $error("accumulator holds more than one digit");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && end_r) |=> mode_r == MODE_NORMAL)
    else $error("end of text left decoder outside start state");

  a_multi_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_load && grp.cnt != 2'd1) |-> mode_r == MODE_HEX3)
    else $error("multi-byte result outside a unicode escape");

endmodule

FILE: rtl/jsu_emit.sv
module jsu_emit import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_load,
  input  grp_t       grp,
  output logic       grp_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_has_byte,
  output logic       out_string_done,
  output logic [2:0] out_error_code,
  output logic       out_last_of_run
);

  logic [1:0]        cnt_r;
  logic [1:0]        idx_r;
  res_t [MaxRes-1:0] ent_r;
  res_t              cur;
  logic              last;

  assign cur             = ent_r[idx_r];
  assign last            = idx_r == cnt_r - 2'd1;
  assign out_valid       = cnt_r != 2'd0;
  assign out_data_byte   = cur.data;
  assign out_has_byte    = cur.has;
  assign out_string_done = cur.done;
  assign out_error_code  = cur.err;
  assign out_last_of_run = last;
  assign grp_free        = !out_valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (grp_load) begin
      cnt_r <= grp.cnt;
      idx_r <= '0;
    end else if (out_valid && out_ready) begin
      if (last) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
    if (grp_load) begin
      ent_r <= grp.ent;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < cnt_r)
    else $error("result index past group size");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    grp_load |-> grp_free)
    else $error("group loaded over pending results");

  a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_string_done) |-> (out_last_of_run && !out_has_byte))
    else $error("string end result carries a byte");

  a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE && out_error_code != ERR_UNTERM)
      |-> (!out_has_byte && out_last_of_run))
    else $error("error result carries a byte");

endmodule

FILE: rtl/json_string_unescape_unit.sv
// An input transfer reaches its first result through the input register, then the
// result register; further bytes of a \u expansion follow from the result register.
// Throughput: one input byte per cycle while results can be taken; a byte that
// expands to n results holds the result register until all n are taken.
// Reset (rst_n low, synchronous): decoder returns to the start state, accumulator
// clears, input and result registers empty.
module json_string_unescape_unit import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_has_byte,
  output logic       out_string_done,
  output logic [2:0] out_error_code,
  output logic       out_last_of_run
);

  logic grp_free;
  logic grp_load;
  grp_t grp;

  jsu_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .in_end_of_text (in_end_of_text),
    .grp_free       (grp_free),
    .grp_load       (grp_load),
    .grp            (grp)
  );

  jsu_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .grp_load        (grp_load),
    .grp             (grp),
    .grp_free        (grp_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_has_byte    (out_has_byte),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule
